// File: design/psp_pkg.sv
// Shared types, codes and constants for the power stage protection monitor.
// No dependencies; every other file in the design imports this package.
package psp_pkg;

    // Event codes carried in the input tuser field
    typedef enum logic [2:0] {
        FUNC_SHORT      = 3'd0,
        FUNC_LOWBAT     = 3'd1,
        FUNC_TICK       = 3'd2,
        FUNC_HW_FAULT   = 3'd3,
        FUNC_AUTO_CLR   = 3'd4,
        FUNC_MANUAL_CLR = 3'd5
    } psp_func_t;

    // Error level codes
    typedef enum logic [1:0] {
        LVL_NONE   = 2'd0,
        LVL_WARN   = 2'd1,
        LVL_AUTO   = 2'd2,
        LVL_MANUAL = 2'd3
    } psp_level_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_UVLO_LIMIT     = 3'd0,
        CFG_BATLOW_LIMIT   = 3'd1,
        CFG_BATLOW_RECOVER = 3'd2,
        CFG_SHORT_VOLT     = 3'd3,
        CFG_SHORT_CURR     = 3'd4,
        CFG_OV_A           = 3'd5,
        CFG_OV_B           = 3'd6,
        CFG_OC_ARRAY       = 3'd7
    } psp_cfg_idx_t;

    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int SAMPLE_W   = 16;
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;

    // Fault bit positions
    localparam int FB_LOWBAT  = 0;
    localparam int FB_SHORT_A = 1;
    localparam int FB_SHORT_B = 2;
    localparam int FB_OV_A    = 3;
    localparam int FB_OC_A    = 4;
    localparam int FB_OC_SUP  = 5;
    localparam int FB_OV_B    = 6;
    localparam int FB_OC_B    = 7;

    // Fixed thresholds and step sizes
    localparam logic [16:0] SCORE_ADD_A     = 17'd600;
    localparam logic [16:0] SCORE_ADD_B     = 17'd300;
    localparam logic [15:0] SCORE_TRIP      = 16'd1700;
    localparam logic [10:0] LOWBAT_DEBOUNCE = 11'd1000;
    localparam logic [10:0] LOWBAT_CNT_MAX  = 11'd2047;
    localparam logic [11:0] POWEROFF_LIMIT  = 12'd2000;
    localparam logic [11:0] POWEROFF_MAX    = 12'd4095;

    localparam logic [CFG_W-1:0] UVLO_RECOVERY_MV_DEF = 15'd8000;
    localparam logic [CFG_W-1:0] OCP_SUPPLY_MA_DEF    = 15'd15000;

    // Configuration register file contents
    typedef struct packed {
        logic [CFG_W-1:0] uvlo_limit_mv;
        logic [CFG_W-1:0] battery_low_limit_mv;
        logic [CFG_W-1:0] battery_low_recovery_mv;
        logic [CFG_W-1:0] short_voltage_mv;
        logic [CFG_W-1:0] short_current_ma;
        logic [CFG_W-1:0] overvoltage_a_mv;
        logic [CFG_W-1:0] overvoltage_b_mv;
        logic [CFG_W-1:0] overcurrent_array_ma;
    } psp_cfg_t;

    localparam psp_cfg_t CFG_RESET = '{
        uvlo_limit_mv:           15'd7000,
        battery_low_limit_mv:    15'd20000,
        battery_low_recovery_mv: 15'd21000,
        short_voltage_mv:        15'd2000,
        short_current_ma:        15'd10000,
        overvoltage_a_mv:        15'd30000,
        overvoltage_b_mv:        15'd30000,
        overcurrent_array_ma:    15'd20000
    };

    // One input item
    typedef struct packed {
        logic [2:0]                  func;
        logic signed [SAMPLE_W-1:0]  volt_a;
        logic signed [SAMPLE_W-1:0]  curr_a;
        logic signed [SAMPLE_W-1:0]  volt_b;
        logic signed [SAMPLE_W-1:0]  curr_b;
        logic signed [SAMPLE_W-1:0]  curr_supply;
    } psp_item_t;

    // One result item
    typedef struct packed {
        psp_level_t                  level;
        logic [7:0]                  fault_bits;
        logic                        drive_enable;
        logic signed [SAMPLE_W-1:0]  fault_volt;
        logic signed [SAMPLE_W-1:0]  fault_curr;
        logic [15:0]                 short_score;
    } psp_result_t;

    // Protection state
    typedef struct packed {
        psp_level_t                  level;
        logic [7:0]                  fault;
        logic                        lowbat_flag;
        logic [10:0]                 lowbat_count;
        logic [15:0]                 short_count;
        logic [11:0]                 poweroff_count;
        logic                        enable;
        logic signed [SAMPLE_W-1:0]  latched_volt;
        logic signed [SAMPLE_W-1:0]  latched_curr;
    } psp_state_t;

endpackage

// File: design/psp_cfg_regs.sv
// Configuration register file: eight 15-bit thresholds with reset defaults.
// Depends on psp_pkg for the register layout and index codes.
module psp_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [psp_pkg::CFG_W-1:0]     cfg_wdata,
    output psp_pkg::psp_cfg_t             cfg
);
    import psp_pkg::*;

    psp_cfg_t cfg_reg;
    psp_cfg_t cfg_next;

    // Decode the write index
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (psp_cfg_idx_t'(cfg_addr))
                CFG_UVLO_LIMIT:     cfg_next.uvlo_limit_mv           = cfg_wdata;
                CFG_BATLOW_LIMIT:   cfg_next.battery_low_limit_mv    = cfg_wdata;
                CFG_BATLOW_RECOVER: cfg_next.battery_low_recovery_mv = cfg_wdata;
                CFG_SHORT_VOLT:     cfg_next.short_voltage_mv        = cfg_wdata;
                CFG_SHORT_CURR:     cfg_next.short_current_ma        = cfg_wdata;
                CFG_OV_A:           cfg_next.overvoltage_a_mv        = cfg_wdata;
                CFG_OV_B:           cfg_next.overvoltage_b_mv        = cfg_wdata;
                CFG_OC_ARRAY:       cfg_next.overcurrent_array_ma    = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/psp_core.sv
// Protection state and its combinational update for one event.
// Depends on psp_pkg for item, state, result and configuration types.
module psp_core #(
    parameter logic [psp_pkg::CFG_W-1:0] UVLO_RECOVERY_MV = psp_pkg::UVLO_RECOVERY_MV_DEF,
    parameter logic [psp_pkg::CFG_W-1:0] OCP_SUPPLY_MA    = psp_pkg::OCP_SUPPLY_MA_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  psp_pkg::psp_item_t    item,
    input  psp_pkg::psp_cfg_t     cfg,
    output psp_pkg::psp_result_t  result_next
);
    import psp_pkg::*;

    psp_state_t state_reg;
    psp_state_t state_next;

    logic signed [16:0] neg_curr_a;
    logic               short_a;
    logic               short_b;
    logic [16:0]        sum_a;
    logic [16:0]        sum_b;
    logic [7:0]         hw_bits;

    function automatic psp_state_t auto_clear(input psp_state_t s);
        psp_state_t r;
        r = s;
        if (s.level == LVL_AUTO) begin
            r.fault  = '0;
            r.level  = LVL_NONE;
            r.enable = 1'b1;
        end
        return r;
    endfunction

    function automatic psp_state_t manual_clear(input psp_state_t s);
        psp_state_t r;
        r = s;
        if (s.level == LVL_MANUAL) begin
            r.fault       = '0;
            r.short_count = '0;
            r.level       = LVL_NONE;
            r.enable      = 1'b1;
        end
        return r;
    endfunction

    // Sample compares used by the short and hardware-fault event paths
    always_comb begin
        neg_curr_a = -$signed({item.curr_a[SAMPLE_W-1], item.curr_a});
        short_a    = (item.volt_a <= $signed({1'b0, cfg.short_voltage_mv}))
                   && (neg_curr_a >= $signed({2'b00, cfg.short_current_ma}));
        short_b    = (item.volt_b <= $signed({1'b0, cfg.short_voltage_mv}))
                   && (item.curr_b >= $signed({1'b0, cfg.short_current_ma}));
        hw_bits             = '0;
        hw_bits[FB_OV_A]    = item.volt_a > $signed({1'b0, cfg.overvoltage_a_mv});
        hw_bits[FB_OC_A]    = item.curr_a > $signed({1'b0, cfg.overcurrent_array_ma});
        hw_bits[FB_OC_SUP]  = item.curr_supply > $signed({1'b0, OCP_SUPPLY_MA});
        hw_bits[FB_OV_B]    = item.volt_b > $signed({1'b0, cfg.overvoltage_b_mv});
        hw_bits[FB_OC_B]    = item.curr_b > $signed({1'b0, cfg.overcurrent_array_ma});
    end

    // Apply the event to the state
    always_comb begin
        state_next = state_reg;
        sum_a      = '0;
        sum_b      = '0;
        case (item.func)
            FUNC_SHORT: begin
                if (short_a) begin
                    state_next.level       = LVL_WARN;
                    sum_a                  = {1'b0, state_next.short_count} + SCORE_ADD_A;
                    state_next.short_count = sum_a[16] ? 16'hFFFF : sum_a[15:0];
                    if (state_next.short_count > SCORE_TRIP) begin
                        state_next.enable            = 1'b0;
                        state_next.fault[FB_SHORT_A] = 1'b1;
                        state_next.level             = LVL_MANUAL;
                        state_next.latched_volt      = item.volt_a;
                        state_next.latched_curr      = neg_curr_a[16] ? neg_curr_a[15:0]
                                                     : (neg_curr_a[15] ? 16'sh7FFF
                                                                       : neg_curr_a[15:0]);
                    end
                end
                if (short_b) begin
                    state_next.level       = LVL_WARN;
                    sum_b                  = {1'b0, state_next.short_count} + SCORE_ADD_B;
                    state_next.short_count = sum_b[16] ? 16'hFFFF : sum_b[15:0];
                    if (state_next.short_count > SCORE_TRIP) begin
                        state_next.enable            = 1'b0;
                        state_next.fault[FB_SHORT_B] = 1'b1;
                        state_next.level             = LVL_MANUAL;
                        state_next.latched_volt      = item.volt_b;
                        state_next.latched_curr      = item.curr_b;
                    end
                end
            end
            FUNC_LOWBAT: begin
                if (state_reg.lowbat_flag) begin
                    if (item.volt_a > $signed({1'b0, cfg.battery_low_recovery_mv})
                        || item.volt_a < $signed({1'b0, cfg.uvlo_limit_mv})) begin
                        state_next.lowbat_flag       = 1'b0;
                        state_next.fault[FB_LOWBAT]  = 1'b0;
                        if (state_next.fault == '0) begin
                            state_next.level = LVL_NONE;
                        end
                    end
                end else if (item.volt_a < $signed({1'b0, cfg.battery_low_limit_mv})
                             && item.volt_a > $signed({1'b0, UVLO_RECOVERY_MV})) begin
                    if (state_next.lowbat_count < LOWBAT_CNT_MAX) begin
                        state_next.lowbat_count = state_next.lowbat_count + 11'd1;
                    end
                    if (state_next.lowbat_count > LOWBAT_DEBOUNCE) begin
                        if (state_next.level == LVL_NONE) begin
                            state_next.level = LVL_WARN;
                        end
                        state_next.lowbat_flag      = 1'b1;
                        state_next.fault[FB_LOWBAT] = 1'b1;
                        state_next.lowbat_count     = '0;
                    end
                end
            end
            FUNC_TICK: begin
                // Leak the score while only a warning is raised
                if (state_next.level == LVL_WARN) begin
                    if (state_next.short_count != '0) begin
                        state_next.short_count = state_next.short_count - 16'd1;
                    end
                    if (state_next.short_count == '0 && !state_next.lowbat_flag) begin
                        state_next.level = LVL_NONE;
                    end
                end
                // Count ticks with the supply gone
                if (item.volt_a < $signed({1'b0, cfg.uvlo_limit_mv})) begin
                    if (state_next.poweroff_count < POWEROFF_MAX) begin
                        state_next.poweroff_count = state_next.poweroff_count + 12'd1;
                    end
                end else begin
                    state_next.poweroff_count = '0;
                end
                if (state_next.poweroff_count > POWEROFF_LIMIT
                    && state_next.level != LVL_NONE) begin
                    state_next = manual_clear(auto_clear(state_next));
                end
            end
            FUNC_HW_FAULT: begin
                if (hw_bits != '0) begin
                    state_next.fault  = state_next.fault | hw_bits;
                    state_next.level  = LVL_AUTO;
                    state_next.enable = 1'b0;
                end
            end
            FUNC_AUTO_CLR:   state_next = auto_clear(state_reg);
            FUNC_MANUAL_CLR: state_next = manual_clear(state_reg);
            default:         state_next = state_reg;
        endcase
    end

    // Hold the state, advance on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{
                level:          LVL_NONE,
                fault:          '0,
                lowbat_flag:    1'b0,
                lowbat_count:   '0,
                short_count:    '0,
                poweroff_count: '0,
                enable:         1'b1,
                latched_volt:   '0,
                latched_curr:   '0
            };
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign result_next = '{
        level:        state_next.level,
        fault_bits:   state_next.fault,
        drive_enable: state_next.enable,
        fault_volt:   state_next.latched_volt,
        fault_curr:   state_next.latched_curr,
        short_score:  state_next.short_count
    };

    // The debounce counter restarts once it passes its limit
    a_lowbat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.lowbat_count <= LOWBAT_DEBOUNCE)
        else $error("low-battery counter beyond debounce limit");

    // Outputs only go off with a short or hardware fault bit standing
    a_disable_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.enable |-> (state_reg.fault[7:1] != '0))
        else $error("drive disabled with no fault bit set");

    // State moves only on a transfer
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(state_reg))
        else $error("state changed without a transfer");

endmodule

// File: design/power_stage_protection_monitor.sv
// Path: an input transfer is captured in the input register; once the result register can
// advance, the state update is registered into it and m_tvalid rises.
// Throughput: one event per cycle; s_tready drops only while the result register is stalled.
// Reset: aresetn is synchronous, active low; it restores the threshold defaults,
// clears the fault state with outputs enabled and empties both registers.
module power_stage_protection_monitor #(
    parameter logic [psp_pkg::CFG_W-1:0] UVLO_RECOVERY_MV = psp_pkg::UVLO_RECOVERY_MV_DEF,
    parameter logic [psp_pkg::CFG_W-1:0] OCP_SUPPLY_MA    = psp_pkg::OCP_SUPPLY_MA_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration writes
    input  logic                           cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [psp_pkg::CFG_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // volt_a[15:0], curr_a[31:16], volt_b[47:32], curr_b[63:48], curr_supply[79:64]
    input  logic [psp_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[2:0]
    input  logic [psp_pkg::IN_USER_W-1:0]  s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // level[1:0], fault_bits[9:2], drive_enable[10], fault_volt[26:11],
    // fault_curr[42:27], short_score[58:43], zeros[63:59]
    output logic [psp_pkg::OUT_DATA_W-1:0] m_tdata
);
    import psp_pkg::*;

    psp_cfg_t    cfg;
    psp_item_t   in_item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    psp_result_t out_reg;
    psp_result_t result_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        core_fire;
    logic        s_xfer;

    psp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    psp_core #(
        .UVLO_RECOVERY_MV (UVLO_RECOVERY_MV),
        .OCP_SUPPLY_MA    (OCP_SUPPLY_MA)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (core_fire),
        .item        (in_item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Pipeline handshake
    always_comb begin
        advance        = !out_valid_reg || m_tready;
        core_fire      = in_valid_reg && advance;
        s_tready       = !in_valid_reg || advance;
        s_xfer         = s_tvalid && s_tready;
        in_valid_next  = s_xfer ? 1'b1 : (core_fire ? 1'b0 : in_valid_reg);
        out_valid_next = core_fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= '{
                func:        s_tuser[2:0],
                volt_a:      s_tdata[15:0],
                curr_a:      s_tdata[31:16],
                volt_b:      s_tdata[47:32],
                curr_b:      s_tdata[63:48],
                curr_supply: s_tdata[79:64]
            };
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (core_fire) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.short_score, out_reg.fault_curr, out_reg.fault_volt,
                       out_reg.drive_enable, out_reg.fault_bits, out_reg.level};

    // Every processed event yields a result next cycle
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        core_fire |=> m_tvalid)
        else $error("processed event produced no result");

    // A result appears only after an event was processed
    a_result_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(core_fire))
        else $error("result appeared without a processed event");

    // An empty input register always takes a transfer
    a_empty_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the power stage protection monitor: random and directed
// events on the input stream, each result checked against an in-bench protection model.
// Depends on psp_pkg and power_stage_protection_monitor from the design folder.
`timescale 1ns / 1ps

module tb;
    import psp_pkg::*;

    // Spare event codes that the block must ignore
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    typedef enum {MIX_GENERAL, MIX_SHORT_STORM, MIX_SUPPLY_LOSS} mix_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    power_stage_protection_monitor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Threshold copy, in register index order
    int cfg_val [8] = '{CFG_RESET.uvlo_limit_mv, CFG_RESET.battery_low_limit_mv,
                        CFG_RESET.battery_low_recovery_mv, CFG_RESET.short_voltage_mv,
                        CFG_RESET.short_current_ma, CFG_RESET.overvoltage_a_mv,
                        CFG_RESET.overvoltage_b_mv, CFG_RESET.overcurrent_array_ma};

    // Protection state as the block should hold it
    psp_level_t        lvl_s        = LVL_NONE;
    logic [7:0]        fault_s      = '0;
    bit                lowbat_s     = 1'b0;
    int                lowbat_cnt_s = 0;
    int                score_s      = 0;
    int                poweroff_s   = 0;
    bit                enable_s     = 1'b1;
    logic signed [15:0] trip_volt_s = '0;
    logic signed [15:0] trip_curr_s = '0;

    psp_item_t   pending [$];
    psp_result_t status_q [$];
    psp_item_t   offer;
    int          accepted  = 0;
    int          failures  = 0;
    int          tx_gap    = 0;
    int          rx_gap    = 0;
    bit          rx_hold_on = 1'b0;
    bit          quiet_tail = 1'b0;

    // ---------------------------------------------------------------------
    // Protection model
    // ---------------------------------------------------------------------
    function automatic void score_bump(int n);
        score_s = score_s + n;
        if (score_s > 65535) score_s = 65535;
    endfunction

    function automatic void clear_auto();
        if (lvl_s == LVL_AUTO) begin
            fault_s  = '0;
            lvl_s    = LVL_NONE;
            enable_s = 1'b1;
        end
    endfunction

    function automatic void clear_manual();
        if (lvl_s == LVL_MANUAL) begin
            fault_s  = '0;
            score_s  = 0;
            lvl_s    = LVL_NONE;
            enable_s = 1'b1;
        end
    endfunction

    // Apply one event to the state and return the status that follows it
    function automatic psp_result_t protect_step(psp_item_t it);
        psp_result_t r;
        logic [7:0]  hw_bits;
        int va, ia, vb, ib, isup, nia;
        va   = $signed(it.volt_a);
        ia   = $signed(it.curr_a);
        vb   = $signed(it.volt_b);
        ib   = $signed(it.curr_b);
        isup = $signed(it.curr_supply);
        nia  = -ia;
        hw_bits = '0;
        case (it.func)
            FUNC_SHORT: begin
                if (va <= cfg_val[CFG_SHORT_VOLT] && nia >= cfg_val[CFG_SHORT_CURR]) begin
                    lvl_s = LVL_WARN;
                    score_bump(int'(SCORE_ADD_A));
                    if (score_s > int'(SCORE_TRIP)) begin
                        enable_s            = 1'b0;
                        fault_s[FB_SHORT_A] = 1'b1;
                        lvl_s               = LVL_MANUAL;
                        trip_volt_s         = 16'(va);
                        // negating the most negative current saturates
                        trip_curr_s         = (nia > 32767) ? 16'sd32767 : 16'(nia);
                    end
                end
                if (vb <= cfg_val[CFG_SHORT_VOLT] && ib >= cfg_val[CFG_SHORT_CURR]) begin
                    lvl_s = LVL_WARN;
                    score_bump(int'(SCORE_ADD_B));
                    if (score_s > int'(SCORE_TRIP)) begin
                        enable_s            = 1'b0;
                        fault_s[FB_SHORT_B] = 1'b1;
                        lvl_s               = LVL_MANUAL;
                        trip_volt_s         = 16'(vb);
                        trip_curr_s         = 16'(ib);
                    end
                end
            end
            FUNC_LOWBAT: begin
                if (lowbat_s) begin
                    if (va > cfg_val[CFG_BATLOW_RECOVER] || va < cfg_val[CFG_UVLO_LIMIT]) begin
                        lowbat_s            = 1'b0;
                        fault_s[FB_LOWBAT]  = 1'b0;
                        if (fault_s == '0) lvl_s = LVL_NONE;
                    end
                end else if (va < cfg_val[CFG_BATLOW_LIMIT]
                             && va > int'(UVLO_RECOVERY_MV_DEF)) begin
                    if (lowbat_cnt_s < int'(LOWBAT_CNT_MAX)) lowbat_cnt_s++;
                    if (lowbat_cnt_s > int'(LOWBAT_DEBOUNCE)) begin
                        if (lvl_s == LVL_NONE) lvl_s = LVL_WARN;
                        lowbat_s           = 1'b1;
                        fault_s[FB_LOWBAT] = 1'b1;
                        lowbat_cnt_s       = 0;
                    end
                end
            end
            FUNC_TICK: begin
                // decay the score while only warning
                if (lvl_s == LVL_WARN) begin
                    if (score_s > 0) score_s--;
                    if (score_s == 0 && !lowbat_s) lvl_s = LVL_NONE;
                end
                if (va < cfg_val[CFG_UVLO_LIMIT]) begin
                    if (poweroff_s < int'(POWEROFF_MAX)) poweroff_s++;
                end else begin
                    poweroff_s = 0;
                end
                // long loss of supply clears both error kinds
                if (poweroff_s > int'(POWEROFF_LIMIT) && lvl_s != LVL_NONE) begin
                    clear_auto();
                    clear_manual();
                end
            end
            FUNC_HW_FAULT: begin
                hw_bits[FB_OV_A]   = va > cfg_val[CFG_OV_A];
                hw_bits[FB_OC_A]   = ia > cfg_val[CFG_OC_ARRAY];
                hw_bits[FB_OC_SUP] = isup > int'(OCP_SUPPLY_MA_DEF);
                hw_bits[FB_OV_B]   = vb > cfg_val[CFG_OV_B];
                hw_bits[FB_OC_B]   = ib > cfg_val[CFG_OC_ARRAY];
                if (hw_bits != '0) begin
                    fault_s  = fault_s | hw_bits;
                    lvl_s    = LVL_AUTO;
                    enable_s = 1'b0;
                end
            end
            FUNC_AUTO_CLR:   clear_auto();
            FUNC_MANUAL_CLR: clear_manual();
            default: ;
        endcase
        r.level        = lvl_s;
        r.fault_bits   = fault_s;
        r.drive_enable = enable_s;
        r.fault_volt   = trip_volt_s;
        r.fault_curr   = trip_curr_s;
        r.short_score  = 16'(score_s);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic int in_range(int lo, int hi);
        if (hi <= lo) return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic psp_item_t make_event(mix_t mix);
        psp_item_t it;
        int pick, sv, sc, uv, bl, br;
        sv = cfg_val[CFG_SHORT_VOLT];
        sc = cfg_val[CFG_SHORT_CURR];
        uv = cfg_val[CFG_UVLO_LIMIT];
        bl = cfg_val[CFG_BATLOW_LIMIT];
        br = cfg_val[CFG_BATLOW_RECOVER];
        it.func        = 3'($urandom_range(0, 7));
        it.volt_a      = 16'($urandom);
        it.curr_a      = 16'($urandom);
        it.volt_b      = 16'($urandom);
        it.curr_b      = 16'($urandom);
        it.curr_supply = 16'($urandom);
        pick = $urandom_range(0, 99);

        if (mix == MIX_SUPPLY_LOSS) begin
            // mostly ticks below the supply limit, with a steady battery drain
            if (pick < 78) begin
                it.func   = FUNC_TICK;
                it.volt_a = 16'(in_range(-32768, uv - 1));
                return it;
            end
            if (pick < 98) begin
                it.func   = FUNC_LOWBAT;
                it.volt_a = 16'(in_range(int'(UVLO_RECOVERY_MV_DEF) + 1, bl - 1));
                return it;
            end
            case ($urandom_range(0, 3))
                0:       it.func = FUNC_SHORT;
                1:       it.func = FUNC_HW_FAULT;
                2:       it.func = FUNC_AUTO_CLR;
                default: it.func = FUNC_MANUAL_CLR;
            endcase
        end else if (mix == MIX_SHORT_STORM) begin
            it.func = FUNC_SHORT;
            if ($urandom_range(0, 9) != 0) begin
                it.volt_a = 16'(in_range(-32768, sv));
                it.curr_a = 16'(in_range(-32768, -sc));
            end
            if ($urandom_range(0, 9) != 0) begin
                it.volt_b = 16'(in_range(-32768, sv));
                it.curr_b = 16'(in_range(sc, 32767));
            end
            return it;
        end else begin
            if (pick < 30)      it.func = FUNC_SHORT;
            else if (pick < 45) it.func = FUNC_LOWBAT;
            else if (pick < 68) it.func = FUNC_TICK;
            else if (pick < 80) it.func = FUNC_HW_FAULT;
            else if (pick < 87) it.func = FUNC_AUTO_CLR;
            else if (pick < 94) it.func = FUNC_MANUAL_CLR;
        end

        // Shape the samples around the thresholds that the event looks at
        case (it.func)
            FUNC_SHORT: begin
                case ($urandom_range(0, 3))
                    0: begin
                        it.volt_a = 16'(in_range(-32768, sv));
                        it.curr_a = 16'(in_range(-32768, -sc));
                    end
                    1: begin
                        it.volt_a = 16'(sv + int'($urandom_range(0, 1)));
                        it.curr_a = 16'(int'($urandom_range(0, 1)) - sc);
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0: begin
                        it.volt_b = 16'(in_range(-32768, sv));
                        it.curr_b = 16'(in_range(sc, 32767));
                    end
                    1: begin
                        it.volt_b = 16'(sv + int'($urandom_range(0, 1)));
                        it.curr_b = 16'(sc - int'($urandom_range(0, 1)));
                    end
                    default: ;
                endcase
            end
            FUNC_LOWBAT: begin
                case ($urandom_range(0, 5))
                    0, 1, 2: it.volt_a = 16'(in_range(int'(UVLO_RECOVERY_MV_DEF) + 1, bl - 1));
                    3:       it.volt_a = 16'(br + int'($urandom_range(0, 2)) - 1);
                    4:       it.volt_a = 16'(uv + int'($urandom_range(0, 2)) - 1);
                    default: ;
                endcase
            end
            FUNC_TICK: begin
                if ($urandom_range(0, 1)) it.volt_a = 16'(in_range(-32768, uv - 1));
            end
            FUNC_HW_FAULT: begin
                if ($urandom_range(0, 2) == 0)
                    it.volt_a = 16'(cfg_val[CFG_OV_A] + int'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    it.curr_a = 16'(cfg_val[CFG_OC_ARRAY] + int'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    it.curr_supply = 16'(int'(OCP_SUPPLY_MA_DEF) + int'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    it.volt_b = 16'(cfg_val[CFG_OV_B] + int'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    it.curr_b = 16'(cfg_val[CFG_OC_ARRAY] + int'($urandom_range(0, 1)));
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic queue_event(logic [2:0] f, int va, int ia, int vb, int ib, int isup);
        psp_item_t it;
        it.func        = f;
        it.volt_a      = 16'(va);
        it.curr_a      = 16'(ia);
        it.volt_b      = 16'(vb);
        it.curr_b      = 16'(ib);
        it.curr_supply = 16'(isup);
        pending.push_back(it);
    endtask

    task automatic queue_random(mix_t mix, int count);
        repeat (count) pending.push_back(make_event(mix));
    endtask

    // Wait until every queued event has been transferred and answered
    task automatic drain();
        do @(negedge aclk);
        while (pending.size() != 0 || s_tvalid || status_q.size() != 0);
    endtask

    // Write all eight thresholds, one register per cycle
    task automatic load_thresholds(int uv, int bl, int br, int sv, int sc,
                                   int ova, int ovb, int oc);
        int vals [8];
        vals = '{uv, bl, br, sv, sc, ova, ovb, oc};
        for (int i = 0; i < 8; i++) begin
            @(posedge aclk);
            cfg_we     <= 1'b1;
            cfg_addr   <= psp_cfg_idx_t'(i);
            cfg_wdata  <= vals[i][CFG_W-1:0];
            cfg_val[i]  = vals[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: offer queued events, predict each one at its transfer
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                status_q.push_back(protect_step(offer));
                accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transfer until it is taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0 && !rx_hold_on && !quiet_tail
                         && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(0, 2);
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                offer = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {offer.curr_supply, offer.curr_b, offer.volt_b,
                             offer.curr_a, offer.volt_a};
                s_tuser  <= offer.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest expected status
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        psp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                $error("result transfer with no event outstanding: %h", m_tdata);
                failures++;
            end else begin
                want = status_q.pop_front();
                check_field("level", want.level, m_tdata[1:0]);
                check_field("fault_bits", want.fault_bits, m_tdata[9:2]);
                check_field("drive_enable", want.drive_enable, m_tdata[10]);
                check_field("fault_volt", want.fault_volt, $signed(m_tdata[26:11]));
                check_field("fault_curr", want.fault_curr, $signed(m_tdata[42:27]));
                check_field("short_score", want.short_score, m_tdata[58:43]);
            end
        end
        if (!aresetn || rx_hold_on) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Long receiver hold-off so the block backs up onto its input
    initial begin
        wait (accepted >= 300);
        @(negedge aclk);
        rx_hold_on = 1'b1;
        repeat (60) @(negedge aclk);
        rx_hold_on = 1'b0;
    end

    // Watchdog
    initial begin
        #(10_000_000);
        $display("FAIL power_stage_protection_monitor");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed events on the reset thresholds
        queue_event(FUNC_TICK, 0, 0, 0, 0, 0);
        queue_event(FUNC_SPARE_6, 32767, 32767, 32767, 32767, 32767);
        queue_event(FUNC_SHORT, -32768, -32768, 0, 0, 0);
        queue_event(FUNC_SHORT, 2000, -10000, 2000, 10000, 0);
        // side A trip with the most negative current
        queue_event(FUNC_SHORT, -100, -32768, 0, 0, 0);
        queue_event(FUNC_AUTO_CLR, 0, 0, 0, 0, 0);
        queue_event(FUNC_MANUAL_CLR, 0, 0, 0, 0, 0);
        queue_event(FUNC_HW_FAULT, 32767, 32767, 32767, 32767, 32767);
        // suspected short while in an auto-recover error
        queue_event(FUNC_SHORT, 0, -20000, 0, 0, 0);
        queue_event(FUNC_AUTO_CLR, 0, 0, 0, 0, 0);
        queue_event(FUNC_TICK, 32767, 0, 0, 0, 0);
        queue_event(FUNC_HW_FAULT, 0, 0, 0, 0, 15001);
        queue_event(FUNC_AUTO_CLR, 0, 0, 0, 0, 0);
        // side B builds up to a trip
        repeat (4) queue_event(FUNC_SHORT, 32767, 0, -32768, 32767, 0);
        queue_event(FUNC_MANUAL_CLR, 0, 0, 0, 0, 0);
        queue_event(FUNC_HW_FAULT, 30000, 20000, 30000, 20000, 15000);
        queue_event(FUNC_LOWBAT, 19999, 0, 0, 0, 0);
        queue_event(FUNC_LOWBAT, 8000, 0, 0, 0, 0);
        queue_event(FUNC_LOWBAT, 20000, 0, 0, 0, 0);
        queue_event(FUNC_SPARE_7, -1, -1, -1, -1, -1);
        queue_event(FUNC_TICK, -32768, -32768, -32768, -32768, -32768);

        // General traffic, then a burst that drives the score to saturation
        queue_random(MIX_GENERAL, 400);
        queue_random(MIX_SHORT_STORM, 120);
        queue_random(MIX_GENERAL, 60);
        drain();

        // Lowest thresholds
        load_thresholds(0, 0, 0, 0, 0, 0, 0, 0);
        queue_random(MIX_GENERAL, 120);
        drain();

        // Highest thresholds
        load_thresholds(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        queue_random(MIX_GENERAL, 120);
        drain();

        // Supply loss: long tick runs below the limit and a steady battery drain
        load_thresholds(32767, 20000, 21000, 2000, 10000, 30000, 30000, 20000);
        queue_random(MIX_SUPPLY_LOSS, 400);
        drain();

        // Random thresholds, back to back with no idling
        load_thresholds($urandom_range(0, 12000), $urandom_range(8000, 28000),
                        $urandom_range(20000, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767));
        quiet_tail = 1'b1;
        queue_random(MIX_GENERAL, 200);
        drain();

        // Let any stray result show up before the verdict
        repeat (4) @(posedge aclk);
        if (failures == 0) begin
            $display("PASS power_stage_protection_monitor");
        end else begin
            $display("FAIL power_stage_protection_monitor");
        end
        $finish;
    end

endmodule
